>>> rtl/vhi_pkg.sv
`timescale 1ns / 1ps

package vhi_pkg;

    // Plane geometry limits
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int POS_W      = $clog2(MAX_WIDTH);
    localparam int DIM_W      = 13;
    localparam int PIX_W      = 8;
    localparam int WORD_W     = 5 * PIX_W;

    // Queue between classifier and result serializer
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Configuration port
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_FILTER_MODE  = 2'd2;

    localparam logic MODE_WIENER   = 1'b0;
    localparam logic MODE_BILINEAR = 1'b1;

    localparam logic [DIM_W-1:0] RST_FRAME_WIDTH  = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = DIM_W'(MAX_HEIGHT);

    typedef struct packed {
        logic [DIM_W-1:0] frame_width;
        logic [DIM_W-1:0] frame_height;
        logic             filter_mode;
    } t_cfg;

    // One queued item: candidate pixels by row distance k, emitted from kstart down to kend
    typedef struct packed {
        logic [3:0][PIX_W-1:0] pix;
        logic [POS_W-1:0]      row;
        logic [POS_W-1:0]      col;
        logic [1:0]            kstart;
        logic [1:0]            kend;
    } t_entry;

    typedef struct packed {
        logic              empty;
        logic              full;
        logic [QCNT_W-1:0] count;
    } t_qstat;

    // Map an out-of-range dimension into 1..maxv
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (v > maxv) begin
            res = maxv;
        end
        return res;
    endfunction

    // Average of two pixels, rounded up
    function automatic logic [PIX_W-1:0] avg_up(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b);
        logic [PIX_W:0] s;
        s = {1'b0, a} + {1'b0, b} + (PIX_W+1)'(1);
        return s[PIX_W:1];
    endfunction

    // Six-tap (1,-5,20,20,-5,1) with rounding and clamp to pixel range
    function automatic logic [PIX_W-1:0] six_tap(input logic [PIX_W-1:0] a0,
                                                 input logic [PIX_W-1:0] a1,
                                                 input logic [PIX_W-1:0] a2,
                                                 input logic [PIX_W-1:0] a3,
                                                 input logic [PIX_W-1:0] a4,
                                                 input logic [PIX_W-1:0] a5);
        logic signed [15:0] outer;
        logic signed [15:0] near;
        logic signed [15:0] mid;
        logic signed [15:0] s;
        logic signed [15:0] q;
        logic [PIX_W-1:0]   res;
        outer = signed'({8'd0, a0}) + signed'({8'd0, a5});
        near  = signed'({8'd0, a1}) + signed'({8'd0, a4});
        mid   = signed'({8'd0, a2}) + signed'({8'd0, a3});
        s     = outer - (near <<< 2) - near + (mid <<< 4) + (mid <<< 2) + 16'sd16;
        q     = s >>> 5;
        if (s < 16'sd0) begin
            res = '0;
        end else if (q > 16'sd255) begin
            res = '1;
        end else begin
            res = q[PIX_W-1:0];
        end
        return res;
    endfunction

endpackage

>>> rtl/vhi_front.sv
`timescale 1ns / 1ps

module vhi_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  vhi_pkg::t_cfg        i_cfg,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [7:0]           i_pixel_in,
    input  vhi_pkg::t_qstat      i_qstat,
    output logic                 o_push,
    output vhi_pkg::t_entry      o_entry
);
    import vhi_pkg::*;

    logic [DIM_W-1:0]  w;
    logic [DIM_W-1:0]  h;
    logic [DIM_W-1:0]  col_a;
    logic [DIM_W-1:0]  row_a;
    logic [DIM_W-1:0]  col_n;
    logic [POS_W-1:0]  c;
    logic              is_last;
    logic              emits;
    logic              use_six;
    logic [1:0]        kstart;
    logic              accept;
    logic [QCNT_W:0]   credit;

    logic [POS_W-1:0]  r_col;
    logic [POS_W-1:0]  r_row;
    logic [POS_W-1:0]  n_col;
    logic [POS_W-1:0]  n_row;

    logic              r_s1_valid;
    logic              r_s1_push;
    logic              r_s1_six;
    logic [POS_W-1:0]  r_s1_col;
    logic [POS_W-1:0]  r_s1_row;
    logic [PIX_W-1:0]  r_s1_pix;
    logic [1:0]        r_s1_kstart;
    logic [1:0]        r_s1_kend;

    logic [WORD_W-1:0] r_mem [MAX_WIDTH];
    logic [WORD_W-1:0] r_rd_word;
    logic [WORD_W-1:0] r_fwd_word;
    logic              r_fwd_hit;
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] n_word;

    // Hold off input unless the queue has room for every item in flight
    assign credit  = {1'b0, i_qstat.count} + (QCNT_W+1)'(r_s1_valid && r_s1_push);
    assign o_stall = (credit >= (QCNT_W+1)'(QDEPTH));
    assign accept  = i_valid && !o_stall;

    // Classify the arriving pixel by its position in the plane
    always_comb begin
        w     = clamp_dim(i_cfg.frame_width, DIM_W'(MAX_WIDTH));
        h     = clamp_dim(i_cfg.frame_height, DIM_W'(MAX_HEIGHT));
        col_a = {1'b0, r_col};
        row_a = {1'b0, r_row};
        if (col_a >= w) begin
            col_a = '0;
            row_a = row_a + DIM_W'(1);
        end
        if (row_a >= h) begin
            row_a = '0;
        end
        c       = col_a[POS_W-1:0];
        is_last = (row_a == h - DIM_W'(1));
        emits   = is_last || (row_a >= DIM_W'(3));
        use_six = !is_last && (i_cfg.filter_mode == MODE_WIENER)
                  && (row_a >= DIM_W'(5)) && (row_a + DIM_W'(2) <= h);
        if (!is_last || row_a >= DIM_W'(3)) begin
            kstart = 2'd3;
        end else begin
            kstart = row_a[1:0];
        end
        // Advance the position
        col_n = col_a + DIM_W'(1);
        if (col_n >= w) begin
            n_col = '0;
            if (row_a + DIM_W'(1) >= h) begin
                n_row = '0;
            end else begin
                n_row = POS_W'(row_a + DIM_W'(1));
            end
        end else begin
            n_col = col_n[POS_W-1:0];
            n_row = row_a[POS_W-1:0];
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
            r_fwd_hit  <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            if (accept) begin
                r_col     <= n_col;
                r_row     <= n_row;
                r_fwd_hit <= r_s1_valid && (r_s1_col == c);
            end
        end
    end

    // Stage-one payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_push   <= emits;
            r_s1_six    <= use_six;
            r_s1_col    <= c;
            r_s1_row    <= row_a[POS_W-1:0];
            r_s1_pix    <= i_pixel_in;
            r_s1_kstart <= kstart;
            r_s1_kend   <= is_last ? 2'd0 : 2'd3;
            r_fwd_word  <= n_word;
        end
    end

    // Line store: read on transfer, write back in the next cycle
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_word <= r_mem[c];
        end
        if (r_s1_valid) begin
            r_mem[r_s1_col] <= n_word;
        end
    end

    // Take the word just written when the same column follows directly
    assign word   = r_fwd_hit ? r_fwd_word : r_rd_word;
    assign n_word = {word[WORD_W-PIX_W-1:0], r_s1_pix};

    // Build the queue entry from the five stored rows and the new pixel
    always_comb begin
        o_entry.pix[0] = r_s1_pix;
        o_entry.pix[1] = avg_up(word[7:0], r_s1_pix);
        o_entry.pix[2] = avg_up(word[15:8], word[7:0]);
        if (r_s1_six) begin
            o_entry.pix[3] = six_tap(word[39:32], word[31:24], word[23:16],
                                     word[15:8], word[7:0], r_s1_pix);
        end else begin
            o_entry.pix[3] = avg_up(word[23:16], word[15:8]);
        end
        o_entry.row    = r_s1_row;
        o_entry.col    = r_s1_col;
        o_entry.kstart = r_s1_kstart;
        o_entry.kend   = r_s1_kend;
    end

    assign o_push = r_s1_valid && r_s1_push;

endmodule

>>> rtl/vhi_queue.sv
`timescale 1ns / 1ps

module vhi_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  vhi_pkg::t_entry i_entry,
    input  logic            i_pop,
    output vhi_pkg::t_entry o_head,
    output vhi_pkg::t_qstat o_qstat
);
    import vhi_pkg::*;

    t_entry            r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    assign o_head        = r_mem[r_rd_ptr];
    assign o_qstat.count = r_count;
    assign o_qstat.empty = (r_count == '0);
    assign o_qstat.full  = (r_count == QCNT_W'(QDEPTH));

endmodule

>>> rtl/vhi_back.sv
`timescale 1ns / 1ps

module vhi_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  vhi_pkg::t_entry i_head,
    input  vhi_pkg::t_qstat i_qstat,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [7:0]      o_pixel_out,
    output logic [11:0]     o_out_row,
    output logic [11:0]     o_out_col,
    output logic            o_last_of_item
);
    import vhi_pkg::*;

    logic              advance;
    logic [1:0]        k;
    logic              at_end;

    logic              r_out_valid;
    logic              r_started;
    logic [1:0]        r_k;
    logic [PIX_W-1:0]  r_pix;
    logic [POS_W-1:0]  r_row;
    logic [POS_W-1:0]  r_col;
    logic              r_last;

    // Walk the head entry one result per transfer
    assign advance = !r_out_valid || !i_stall;
    assign k       = r_started ? r_k : i_head.kstart;
    assign at_end  = (k == i_head.kend);
    assign o_pop   = advance && !i_qstat.empty && at_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_started   <= 1'b0;
            r_k         <= '0;
        end else if (advance) begin
            r_out_valid <= !i_qstat.empty;
            if (!i_qstat.empty) begin
                r_started <= !at_end;
                r_k       <= k - 2'd1;
            end
        end
    end

    // Load the output register
    always_ff @(posedge i_clk) begin
        if (advance && !i_qstat.empty) begin
            r_pix  <= i_head.pix[k];
            r_row  <= i_head.row - POS_W'(k);
            r_col  <= i_head.col;
            r_last <= at_end;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_pixel_out    = r_pix;
    assign o_out_row      = r_row;
    assign o_out_col      = r_col;
    assign o_last_of_item = r_last;

endmodule

>>> rtl/vertical_halfpel_interpolator_core.sv
`timescale 1ns / 1ps

// Vertical half-pel interpolator.
// Input channel: one 8-bit source pixel per transfer (i_valid / o_stall), raster order.
// Output channel: pixel, row, column and last-of-item flag per transfer (o_valid / i_stall).
// Configuration: APB-style port; frame_width at 0x0, frame_height at 0x4, filter_mode at 0x8.
//   Write it only while the block is idle.
// Rows 0 to 2 of the source produce no output unless one of them is the last row; from
// row 3 on each pixel yields output row r-3 at its column. Each pixel of the last row
// yields up to four results (the rows that remain), ending with the copied last row.
// Throughput: one pixel per clock while results leave at one per clock; on the last
// row the single output register limits the block to one result per clock, so the
// input is stalled there until the queue has room.
// A result passes the stage-one registers, the queue and the output register in turn.
// The line store is a 4096 x 40-bit memory read at the transfer and written back in the
// next cycle; back-to-back hits on one column are forwarded.
// A four-entry queue separates the classifier from the result serializer; a stall
// on the output fills it, and o_stall rises once queued and in-flight items reach four.
// Reset (synchronous, active low) returns the position to row 0, column 0, empties
// the queue and restores the registers to 4096 x 4096, six-tap mode. The line store
// needs no clearing: each stored row a result uses was written earlier in the frame.
module vertical_halfpel_interpolator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_pixel_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_pixel_out,
    output logic [11:0] o_out_row,
    output logic [11:0] o_out_col,
    output logic        o_last_of_item
);
    import vhi_pkg::*;

    t_cfg       r_cfg;
    logic       cfg_wr;
    t_qstat     q_stat;
    t_entry     q_in;
    t_entry     q_head;
    logic       q_push;
    logic       q_pop;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width  <= RST_FRAME_WIDTH;
            r_cfg.frame_height <= RST_FRAME_HEIGHT;
            r_cfg.filter_mode  <= MODE_WIENER;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_FRAME_WIDTH:  r_cfg.frame_width  <= pwdata[DIM_W-1:0];
                REG_FRAME_HEIGHT: r_cfg.frame_height <= pwdata[DIM_W-1:0];
                REG_FILTER_MODE:  r_cfg.filter_mode  <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Register read back
    always_comb begin
        unique case (paddr[3:2])
            REG_FRAME_WIDTH:  prdata = {{(DATA_W-DIM_W){1'b0}}, r_cfg.frame_width};
            REG_FRAME_HEIGHT: prdata = {{(DATA_W-DIM_W){1'b0}}, r_cfg.frame_height};
            REG_FILTER_MODE:  prdata = {{(DATA_W-1){1'b0}}, r_cfg.filter_mode};
            default:          prdata = '0;
        endcase
    end

    vhi_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_pixel_in (i_pixel_in),
        .i_qstat    (q_stat),
        .o_push     (q_push),
        .o_entry    (q_in)
    );

    vhi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_qstat (q_stat)
    );

    vhi_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (q_head),
        .i_qstat        (q_stat),
        .o_pop          (q_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_pixel_out    (o_pixel_out),
        .o_out_row      (o_out_row),
        .o_out_col      (o_out_col),
        .o_last_of_item (o_last_of_item)
    );

`ifndef SYNTHESIS
    // Credit check must keep pushes away from a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && q_stat.full && !q_pop))
        else $error("queue push while full");

    // Serializer never pops an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_pop && q_stat.empty))
        else $error("queue pop while empty");

    // A full queue must hold off the input side
    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.full |-> o_stall)
        else $error("input open while queue full");

    // Output is empty right after reset
    a_reset_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_valid)
        else $error("output valid right after reset");
`endif

endmodule

>>> verif/vertical_halfpel_interpolator_core_tb.sv
`timescale 1ns / 1ps

module vertical_halfpel_interpolator_core_tb;
    import vhi_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 12;
    localparam int TAIL_CYCLES    = 20;
    localparam int REPORT_CAP     = 20;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic [11:0]      row;
        logic [11:0]      col;
        logic             closes_item;
    } t_halfpel_result;

    typedef logic [PIX_W-1:0] t_pix_list [$];

    // Tracks plane position and column history, predicts the half-pel results
    class t_halfpel_scoreboard;
        logic [DIM_W-1:0]  width_reg;
        logic [DIM_W-1:0]  height_reg;
        logic              mode_reg;
        logic [WORD_W-1:0] column_hist [MAX_WIDTH];
        int                next_col;
        int                next_row;
        t_halfpel_result   due_pels [$];
        int                errors;

        function new();
            width_reg  = RST_FRAME_WIDTH;
            height_reg = RST_FRAME_HEIGHT;
            mode_reg   = MODE_WIENER;
            foreach (column_hist[i]) column_hist[i] = '0;
            next_col = 0;
            next_row = 0;
            errors   = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [DATA_W-1:0] val);
            case (idx)
                REG_FRAME_WIDTH:  width_reg  = val[DIM_W-1:0];
                REG_FRAME_HEIGHT: height_reg = val[DIM_W-1:0];
                REG_FILTER_MODE:  mode_reg   = val[0];
                default: ;
            endcase
        endfunction

        function int usable_dim(logic [DIM_W-1:0] v, int limit);
            if (v == '0) return 1;
            if (int'(v) > limit) return limit;
            return int'(v);
        endfunction

        // Pixel of the row k above the current one at this column
        function int row_above(logic [WORD_W-1:0] hist, logic [PIX_W-1:0] cur, int k);
            if (k == 0) return int'(cur);
            return int'(hist[8*(k-1) +: 8]);
        endfunction

        // Six-tap on rows y-2..y+3, where k0 is the distance up to row y-2
        function logic [PIX_W-1:0] wiener_tap(logic [WORD_W-1:0] hist,
                                              logic [PIX_W-1:0] cur, int k0);
            int acc;
            int q;
            acc = row_above(hist, cur, k0) + row_above(hist, cur, k0 - 5)
                - 5 * (row_above(hist, cur, k0 - 1) + row_above(hist, cur, k0 - 4))
                + 20 * (row_above(hist, cur, k0 - 2) + row_above(hist, cur, k0 - 3))
                + 16;
            q = acc >>> 5;
            if (q < 0) q = 0;
            if (q > 255) q = 255;
            return PIX_W'(q);
        endfunction

        function bit at_frame_start();
            return (next_col == 0) && (next_row == 0);
        endfunction

        function int pending();
            return due_pels.size();
        endfunction

        // Note one accepted source pixel and queue the rows it completes
        function void note_pixel(logic [PIX_W-1:0] pix);
            int w;
            int h;
            int c;
            int r;
            int lo;
            int hi;
            int y;
            int k;
            bit last_row;
            logic [WORD_W-1:0] hist;
            t_halfpel_result res;
            w = usable_dim(width_reg, MAX_WIDTH);
            h = usable_dim(height_reg, MAX_HEIGHT);
            // Re-fit the position to the current geometry
            if (next_col >= w) begin
                next_col = 0;
                next_row++;
            end
            if (next_row >= h) next_row = 0;
            c = next_col;
            r = next_row;
            hist = column_hist[c];
            last_row = (r == h - 1);
            if (last_row || r >= 3) begin
                lo = (r >= 3) ? r - 3 : 0;
                hi = last_row ? r : r - 3;
                for (y = lo; y <= hi; y++) begin
                    k = r - y;
                    if (y == h - 1) begin
                        res.pix = pix;
                    end else if (mode_reg == MODE_WIENER && y >= 2 && y + 5 <= h) begin
                        res.pix = wiener_tap(hist, pix, k + 2);
                    end else begin
                        res.pix = PIX_W'((row_above(hist, pix, k)
                                          + row_above(hist, pix, k - 1) + 1) >> 1);
                    end
                    res.row = 12'(y);
                    res.col = 12'(c);
                    res.closes_item = (y == hi);
                    due_pels.push_back(res);
                end
            end
            // Shift this pixel into the column history and advance
            column_hist[c] = {hist[WORD_W-9:0], pix};
            next_col = c + 1;
            if (next_col >= w) begin
                next_col = 0;
                next_row = (r + 1 >= h) ? 0 : r + 1;
            end
        endfunction

        function void check_result(logic [PIX_W-1:0] pix, logic [11:0] row,
                                   logic [11:0] col, logic closes_item);
            t_halfpel_result want;
            if (due_pels.size() == 0) begin
                errors++;
                if (errors <= REPORT_CAP)
                    $display("%0t: unexpected result: pixel %0d row %0d col %0d last %0b",
                             $time, pix, row, col, closes_item);
                return;
            end
            want = due_pels.pop_front();
            if (want.pix !== pix || want.row !== row || want.col !== col
                    || want.closes_item !== closes_item) begin
                errors++;
                if (errors <= REPORT_CAP) begin
                    if (want.pix !== pix)
                        $display("%0t: pixel_out mismatch: expected %0d, actual %0d",
                                 $time, want.pix, pix);
                    if (want.row !== row)
                        $display("%0t: out_row mismatch: expected %0d, actual %0d",
                                 $time, want.row, row);
                    if (want.col !== col)
                        $display("%0t: out_col mismatch: expected %0d, actual %0d",
                                 $time, want.col, col);
                    if (want.closes_item !== closes_item)
                        $display("%0t: last_of_item mismatch: expected %0b, actual %0b",
                                 $time, want.closes_item, closes_item);
                end
            end
        endfunction
    endclass

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              psel       = 1'b0;
    logic              penable    = 1'b0;
    logic              pwrite     = 1'b0;
    logic [ADDR_W-1:0] paddr      = '0;
    logic [DATA_W-1:0] pwdata     = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              i_valid    = 1'b0;
    logic              o_stall;
    logic [PIX_W-1:0]  i_pixel_in = '0;
    logic              o_valid;
    logic              i_stall    = 1'b0;
    logic [PIX_W-1:0]  o_pixel_out;
    logic [11:0]       o_out_row;
    logic [11:0]       o_out_col;
    logic              o_last_of_item;

    t_halfpel_scoreboard halfpel_sb = new();

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned quiet_cycles  = 0;

    vertical_halfpel_interpolator_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_pixel_in     (i_pixel_in),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_pixel_out    (o_pixel_out),
        .o_out_row      (o_out_row),
        .o_out_col      (o_out_col),
        .o_last_of_item (o_last_of_item)
    );

    always #5 i_clk = ~i_clk;

    // Take results, stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            halfpel_sb.check_result(o_pixel_out, o_out_row, o_out_col, o_last_of_item);
        end
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Abort when no transfer happens for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one pixel, hold it until the transfer; valid stays high afterward
    task automatic send_pixel(input logic [PIX_W-1:0] pix);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_pixel_in <= pix;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        halfpel_sb.note_pixel(pix);
    endtask

    task automatic send_list(input t_pix_list pels);
        foreach (pels[i]) send_pixel(pels[i]);
    endtask

    // Feed random pixels until the plane wraps back to row 0, column 0
    task automatic finish_frame();
        do begin
            send_pixel(PIX_W'($urandom));
        end while (!halfpel_sb.at_frame_start());
    endtask

    // Drop valid, wait for every expected result, then let the pipeline empty
    task automatic settle_block();
        i_valid <= 1'b0;
        while (halfpel_sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        halfpel_sb.write_reg(idx, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_geometry(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                                input logic mode);
        settle_block();
        cfg_write(REG_FRAME_WIDTH, DATA_W'(w));
        cfg_write(REG_FRAME_HEIGHT, DATA_W'(h));
        cfg_write(REG_FILTER_MODE, DATA_W'(mode));
    endtask

    // Whole small frames of random geometry; some frames use only 0 and 255
    task automatic run_random_frames(input int quota);
        int sent;
        int w;
        int h;
        int n;
        bit binary;
        logic [PIX_W-1:0] pix;
        sent = 0;
        while (sent < quota) begin
            w = $urandom_range(1, 5);
            h = ($urandom_range(3) == 0) ? $urandom_range(1, 7) : $urandom_range(8, 10);
            set_geometry(DIM_W'(w), DIM_W'(h), logic'($urandom_range(1)));
            binary = ($urandom_range(3) == 0);
            for (n = 0; n < w * h; n++) begin
                pix = binary ? ($urandom_range(1) ? 8'hFF : 8'h00) : PIX_W'($urandom);
                send_pixel(pix);
            end
            sent += w * h;
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 9;
        recv_idle_pct = 51;

        // Six-tap clamped high, then clamped low, on a one-column plane
        set_geometry(DIM_W'(1), DIM_W'(7), MODE_WIENER);
        send_list('{8'd0, 8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 8'd128});
        send_list('{8'd255, 8'd255, 8'd0, 8'd0, 8'd255, 8'd255, 8'd0});
        // Height zero acts as one: every pixel is copied
        set_geometry(DIM_W'(2), DIM_W'(0), MODE_BILINEAR);
        send_list('{8'd255, 8'd0});
        // Short planes flush all rows from row 0
        set_geometry(DIM_W'(1), DIM_W'(3), MODE_BILINEAR);
        send_list('{8'd255, 8'd254, 8'd1});
        set_geometry(DIM_W'(1), DIM_W'(2), MODE_WIENER);
        send_list('{8'd0, 8'd255});

        // Oversized height, then lowered below the current row: plane restarts
        set_geometry(DIM_W'(0), 13'h1FFF, MODE_WIENER);
        repeat (10) send_pixel(PIX_W'($urandom));
        set_geometry(DIM_W'(0), DIM_W'(8), MODE_WIENER);
        finish_frame();
        // Oversized width, then lowered below the current column: next row starts
        set_geometry(13'h1FFF, DIM_W'(8), MODE_WIENER);
        repeat (6) send_pixel(PIX_W'($urandom));
        set_geometry(DIM_W'(3), DIM_W'(8), MODE_WIENER);
        finish_frame();

        run_random_frames(15);

        send_idle_pct = 51;
        recv_idle_pct = 9;
        run_random_frames(15);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_frames(15);

        settle_block();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (halfpel_sb.errors == 0 && halfpel_sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> vertical_halfpel_interpolator_core.f
rtl/vhi_pkg.sv
rtl/vhi_front.sv
rtl/vhi_queue.sv
rtl/vhi_back.sv
rtl/vertical_halfpel_interpolator_core.sv
verif/vertical_halfpel_interpolator_core_tb.sv
